>>> design/tlsm_pkg.sv
// ----------------------------------------------------------------------------
// tlsm_pkg: shared types and constants for the three-point smoother
// Sample and result formats, pipeline control structs, divide-by-three
// constants and the rounding tables used to rebuild the fixed-point output.
// ----------------------------------------------------------------------------
package tlsm_pkg;

	// Sample and output formats
	localparam int SAMPLE_WIDTH = 16;
	localparam int FRAC_BITS    = 8;
	localparam int OUT_WIDTH    = SAMPLE_WIDTH + FRAC_BITS + 1;

	// Numerators such as 5*a0 + 2*a1 - a2 need three guard bits
	localparam int NUM_W  = SAMPLE_WIDTH + 3;
	localparam int WIDE_W = NUM_W + FRAC_BITS;

	// Divide-by-three unit: operand offset to unsigned, reciprocal
	localparam int DIV_M = NUM_W + 1;
	localparam logic [DIV_M-1:0] DIV_RECIP = DIV_M'((64'd1 << DIV_M) / 64'd3);
	localparam logic [DIV_M-1:0] DIV_OFS   = DIV_M'(64'd3 << (NUM_W - 1));
	localparam logic [DIV_M-1:0] DIV_BIAS  = DIV_M'(64'd1 << (NUM_W - 1));

	// Result queue
	localparam int RES_MAX    = 3;
	localparam int OUTQ_DEPTH = 16;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
	localparam int CREDIT_W   = $clog2(OUTQ_DEPTH + 1);

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [NUM_W-1:0]        num_t;
	typedef logic signed [OUT_WIDTH-1:0]    smooth_t;
	typedef logic [FRAC_BITS:0]             frac_t;
	typedef logic [1:0]                     seen_t;
	typedef logic [1:0]                     rescnt_t;

	// Position of the current sample within its block (saturating)
	localparam seen_t SEEN_NONE = 2'd0;
	localparam seen_t SEEN_ONE  = 2'd1;
	localparam seen_t SEEN_TWO  = 2'd2;
	localparam seen_t SEEN_MORE = 2'd3;

	typedef struct packed {
		sample_t sample;
		logic    is_last;
	} in_item_t;

	typedef struct packed {
		smooth_t smoothed;
		logic    last_out;
	} out_item_t;

	typedef struct packed {
		logic  valid;
		seen_t seen;
		logic  last;
	} ctl_t;

	typedef struct packed {
		ctl_t    ctl;
		logic    bit_first;
		logic    bit_last;
		sample_t pass1;
		sample_t pass2;
	} meta_t;

	// Rounding fraction: floor((r*2^(F+1) + d) / (2d)) for remainder r of divisor d
	localparam logic [63:0] RND_SCALE = 64'd1 << (FRAC_BITS + 1);
	localparam frac_t RND3_R0 = frac_t'(64'd3 / 64'd6);
	localparam frac_t RND3_R1 = frac_t'((RND_SCALE + 64'd3) / 64'd6);
	localparam frac_t RND3_R2 = frac_t'((64'd2 * RND_SCALE + 64'd3) / 64'd6);
	localparam frac_t RND6_R0 = frac_t'(64'd6 / 64'd12);
	localparam frac_t RND6_R1 = frac_t'((RND_SCALE + 64'd6) / 64'd12);
	localparam frac_t RND6_R2 = frac_t'((64'd2 * RND_SCALE + 64'd6) / 64'd12);
	localparam frac_t RND6_R3 = frac_t'((64'd3 * RND_SCALE + 64'd6) / 64'd12);
	localparam frac_t RND6_R4 = frac_t'((64'd4 * RND_SCALE + 64'd6) / 64'd12);
	localparam frac_t RND6_R5 = frac_t'((64'd5 * RND_SCALE + 64'd6) / 64'd12);

	function automatic frac_t rnd3(input logic [1:0] r);
		frac_t v;
		case (r)
			2'd0: v = RND3_R0;
			2'd1: v = RND3_R1;
			2'd2: v = RND3_R2;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic frac_t rnd6(input logic [2:0] r);
		frac_t v;
		case (r)
			3'd0: v = RND6_R0;
			3'd1: v = RND6_R1;
			3'd2: v = RND6_R2;
			3'd3: v = RND6_R3;
			3'd4: v = RND6_R4;
			3'd5: v = RND6_R5;
			default: v = '0;
		endcase
		return v;
	endfunction

	// quotient * 2^F + rounding fraction
	function automatic smooth_t scale_quot(input num_t k, input frac_t rnd);
		logic [WIDE_W-1:0] wide;
		wide = (WIDE_W'(k) << FRAC_BITS) + WIDE_W'(rnd);
		return wide[OUT_WIDTH-1:0];
	endfunction

	// Pass-through sample scaled to the output format
	function automatic smooth_t scale_sample(input sample_t a);
		smooth_t ext;
		ext = OUT_WIDTH'(a);
		return ext <<< FRAC_BITS;
	endfunction

	// Number of results one request produces
	function automatic rescnt_t res_count(input seen_t seen, input logic last);
		rescnt_t c;
		case (seen)
			SEEN_NONE: c = last ? 2'd1 : 2'd0;
			SEEN_ONE:  c = last ? 2'd2 : 2'd0;
			SEEN_TWO:  c = last ? 2'd3 : 2'd2;
			default:   c = last ? 2'd2 : 2'd1;
		endcase
		return c;
	endfunction

endpackage

>>> design/tlsm_cell.sv
// ----------------------------------------------------------------------------
// tlsm_cell: one sample cell of the smoothing window
// Holds one sample and loads its upstream neighbor's sample on each shift.
// ----------------------------------------------------------------------------
module tlsm_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  tlsm_pkg::sample_t d,
	output tlsm_pkg::sample_t q
);
	import tlsm_pkg::*;

	sample_t sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule

>>> design/tlsm_div3.sv
// ----------------------------------------------------------------------------
// tlsm_div3: pipelined floor division by three
// Signed operand in, floor quotient and remainder (0..2) out; the offset, the
// reciprocal multiply and a single compare-and-subtract fixup each end in a register.
// ----------------------------------------------------------------------------
module tlsm_div3 (
	input  logic                 clk,
	input  tlsm_pkg::num_t       x,
	output tlsm_pkg::num_t       quot,
	output logic [1:0]           rem
);
	import tlsm_pkg::*;

	logic [DIV_M-1:0]   xu_s1;
	logic [DIV_M-1:0]   xu_s2;
	logic [2*DIV_M-1:0] prod_s2;
	num_t               quot_s3;
	logic [1:0]         rem_s3;

	logic [DIV_M-1:0] q0;
	logic [DIV_M-1:0] three_q;
	logic [DIV_M-1:0] r_full;
	logic [2:0]       r_lo;
	logic [DIV_M-1:0] q_fix;
	logic [2:0]       r_fix;
	logic [DIV_M-1:0] q_signed;

	// Offset to unsigned, then reciprocal multiply
	always_ff @(posedge clk) begin
		xu_s1   <= DIV_M'(x) + DIV_OFS;
		xu_s2   <= xu_s1;
		prod_s2 <= xu_s1 * DIV_RECIP;
	end

	// Estimate is the true quotient or one short; remainder tells which
	always_comb begin
		q0       = prod_s2[2*DIV_M-1:DIV_M];
		three_q  = (q0 << 1) + q0;
		r_full   = xu_s2 - three_q;
		r_lo     = r_full[2:0];
		if (r_lo >= 3'd3) begin
			q_fix = q0 + DIV_M'(1);
			r_fix = r_lo - 3'd3;
		end else begin
			q_fix = q0;
			r_fix = r_lo;
		end
		q_signed = q_fix - DIV_BIAS;
	end

	always_ff @(posedge clk) begin
		quot_s3 <= q_signed[NUM_W-1:0];
		rem_s3  <= r_fix[1:0];
	end

	assign quot = quot_s3;
	assign rem  = rem_s3;

endmodule

>>> design/tlsm_outq.sv
// ----------------------------------------------------------------------------
// tlsm_outq: result queue
// Takes up to three results per cycle in order, hands out one per cycle while the receiver is ready.
// Space is reserved upstream, so the queue never sees an overflowing push.
// ----------------------------------------------------------------------------
module tlsm_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tlsm_pkg::rescnt_t    push_num,
	input  tlsm_pkg::out_item_t  push_item [tlsm_pkg::RES_MAX],
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output tlsm_pkg::out_item_t  pop_item
);
	import tlsm_pkg::*;

	out_item_t           mem_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]  wr_ptr_q;
	logic [OUTQ_AW-1:0]  rd_ptr_q;
	logic [CREDIT_W-1:0] count_q;
	logic                pop;

	assign pop       = pop_valid & pop_ready;
	assign pop_valid = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];

	// Storage writes, consecutive slots from the write pointer
	always_ff @(posedge clk) begin
		for (int j = 0; j < RES_MAX; j++) begin
			if (push_num > rescnt_t'(j)) begin
				mem_q[wr_ptr_q + OUTQ_AW'(j)] <= push_item[j];
			end
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUTQ_AW'(push_num);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUTQ_AW'(1);
			end
			count_q <= count_q + CREDIT_W'(push_num) - CREDIT_W'(pop);
		end
	end

	// A push never runs past the free space
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		((CREDIT_W + 1)'(count_q) + (CREDIT_W + 1)'(push_num))
			<= (CREDIT_W + 1)'(OUTQ_DEPTH))
		else $error("result queue overflow");

endmodule

>>> design/three_point_linear_smoother_core.sv
// ----------------------------------------------------------------------------
// three_point_linear_smoother_core: streaming three-point smoothing filter
// Blocks of signed samples in, smoothed fixed-point samples out.
//
// Usage:
//  - sample channel: one request per sample, is_last marks the block end.
//  - result channel: smoothed value with 8 fraction bits, last_out on the
//    final result of each block. Interior results are the three-point mean,
//    the end points use the (5,2,-1)/6 form; blocks of one or two samples
//    come back scaled but otherwise unchanged.
//  - Results trail the input by one sample; the last sample of a block
//    releases one, two or three results at once.
//  - The first result of a sample travels from acceptance through the window
//    cells, the numerator register, the three-stage divide-by-three lanes
//    and the result queue.
//  - Throughput: one sample per cycle. The 16-entry result queue holds
//    space for every result still in flight; sample_ready drops when fewer
//    than three slots are free, which happens when the receiver stalls or
//    a burst of block ends outruns the one-result-per-cycle drain.
//  - Reset clears the window, the block position, the pipeline control and the queue.
// ----------------------------------------------------------------------------
module three_point_linear_smoother_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  tlsm_pkg::in_item_t  sample_req,
	output logic                result_valid,
	input  logic                result_ready,
	output tlsm_pkg::out_item_t result_req
);
	import tlsm_pkg::*;

	logic                accept;
	logic                pop;
	seen_t               seen_q;
	logic [CREDIT_W-1:0] credit_q;
	sample_t             win [3];

	ctl_t  ctl_s1;
	meta_t meta_s2;
	meta_t meta_s3;
	meta_t meta_s4;
	meta_t meta_s5;
	num_t  n3_s2;
	num_t  n6f_s2;
	num_t  n6l_s2;

	num_t a0;
	num_t a1;
	num_t a2;
	num_t n3_c;
	num_t n6f_c;
	num_t n6l_c;

	num_t       quot_first;
	num_t       quot_mid;
	num_t       quot_last;
	logic [1:0] rem_first;
	logic [1:0] rem_mid;
	logic [1:0] rem_last;

	smooth_t   v_first;
	smooth_t   v_mid;
	smooth_t   v_last;
	smooth_t   v_pass1;
	smooth_t   v_pass2;
	rescnt_t   push_num;
	out_item_t push_item [RES_MAX];

	assign accept       = sample_valid & sample_ready;
	assign pop          = result_valid & result_ready;
	assign sample_ready = (credit_q <= CREDIT_W'(OUTQ_DEPTH - RES_MAX));

	// Window: chain of three cells, newest sample enters at cell 2
	tlsm_cell u_cell2 (.clk(clk), .arst_n(arst_n), .shift(accept),
		.d(sample_req.sample), .q(win[2]));
	tlsm_cell u_cell1 (.clk(clk), .arst_n(arst_n), .shift(accept),
		.d(win[2]), .q(win[1]));
	tlsm_cell u_cell0 (.clk(clk), .arst_n(arst_n), .shift(accept),
		.d(win[1]), .q(win[0]));

	// Block position and queue space reservation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= SEEN_NONE;
			credit_q <= '0;
		end else begin
			if (accept) begin
				if (sample_req.is_last) begin
					seen_q <= SEEN_NONE;
				end else if (seen_q != SEEN_MORE) begin
					seen_q <= seen_q + 2'd1;
				end
			end
			credit_q <= credit_q
				+ (accept ? CREDIT_W'(res_count(seen_q, sample_req.is_last)) : '0)
				- CREDIT_W'(pop);
		end
	end

	// Stage 1: control of the request whose sample just entered the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			ctl_s1.seen  <= seen_q;
			ctl_s1.last  <= sample_req.is_last;
		end
	end

	// Numerators from the current window
	always_comb begin
		a0    = NUM_W'(win[0]);
		a1    = NUM_W'(win[1]);
		a2    = NUM_W'(win[2]);
		n3_c  = a0 + a1 + a2;
		n6f_c = (a0 <<< 2) + a0 + (a1 <<< 1) - a2;
		n6l_c = (a2 <<< 2) + a2 + (a1 <<< 1) - a0;
	end

	always_ff @(posedge clk) begin
		n3_s2  <= n3_c;
		n6f_s2 <= n6f_c;
		n6l_s2 <= n6l_c;
	end

	// Control and pass-through samples travel beside the divide lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s2 <= '0;
			meta_s3 <= '0;
			meta_s4 <= '0;
			meta_s5 <= '0;
		end else begin
			meta_s2.ctl       <= ctl_s1;
			meta_s2.bit_first <= n6f_c[0];
			meta_s2.bit_last  <= n6l_c[0];
			meta_s2.pass1     <= win[1];
			meta_s2.pass2     <= win[2];
			meta_s3           <= meta_s2;
			meta_s4           <= meta_s3;
			meta_s5           <= meta_s4;
		end
	end

	// Divide lanes: x/6 is (x>>>1)/3 with the dropped bit folded into the remainder
	tlsm_div3 u_div_first (.clk(clk), .x(n6f_s2 >>> 1), .quot(quot_first), .rem(rem_first));
	tlsm_div3 u_div_mid   (.clk(clk), .x(n3_s2), .quot(quot_mid), .rem(rem_mid));
	tlsm_div3 u_div_last  (.clk(clk), .x(n6l_s2 >>> 1), .quot(quot_last), .rem(rem_last));

	// Rebuild rounded values and order the results of this request
	always_comb begin
		v_first = scale_quot(quot_first, rnd6({rem_first, meta_s5.bit_first}));
		v_mid   = scale_quot(quot_mid, rnd3(rem_mid));
		v_last  = scale_quot(quot_last, rnd6({rem_last, meta_s5.bit_last}));
		v_pass1 = scale_sample(meta_s5.pass1);
		v_pass2 = scale_sample(meta_s5.pass2);

		push_num = meta_s5.ctl.valid ? res_count(meta_s5.ctl.seen, meta_s5.ctl.last) : '0;
		for (int j = 0; j < RES_MAX; j++) begin
			push_item[j] = '0;
		end
		case (meta_s5.ctl.seen)
			SEEN_NONE: begin
				push_item[0] = '{smoothed: v_pass2, last_out: 1'b1};
			end
			SEEN_ONE: begin
				push_item[0] = '{smoothed: v_pass1, last_out: 1'b0};
				push_item[1] = '{smoothed: v_pass2, last_out: 1'b1};
			end
			SEEN_TWO: begin
				push_item[0] = '{smoothed: v_first, last_out: 1'b0};
				push_item[1] = '{smoothed: v_mid, last_out: 1'b0};
				push_item[2] = '{smoothed: v_last, last_out: 1'b1};
			end
			default: begin
				push_item[0] = '{smoothed: v_mid, last_out: 1'b0};
				push_item[1] = '{smoothed: v_last, last_out: 1'b1};
			end
		endcase
	end

	tlsm_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_num (push_num),
		.push_item(push_item),
		.pop_valid(result_valid),
		.pop_ready(result_ready),
		.pop_item (result_req)
	);

	// Reserved space never exceeds the queue
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CREDIT_W'(OUTQ_DEPTH))
		else $error("queue reservation exceeds depth");

	// A result on offer is always covered by a reservation
	a_credit_covers: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (credit_q != '0))
		else $error("result offered without reservation");

	// No new request is taken while the queue is nearly committed
	a_stall_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		(credit_q > CREDIT_W'(OUTQ_DEPTH - RES_MAX)) |-> !accept)
		else $error("request accepted without queue space");

endmodule
